### hw/rtl/ors_pkg.sv
package ors_pkg;

    // Command codes carried on the input tuser field
    typedef enum logic [2:0] {
        CMD_START_FIRST = 3'd0,
        CMD_START_NEXT  = 3'd1,
        CMD_BIT_RESULT  = 3'd2,
        CMD_TARGET_FAM  = 3'd3,
        CMD_SKIP_FAM    = 3'd4
    } command_t;

    // Status codes carried on the output tuser field
    typedef enum logic [2:0] {
        ST_SEARCHING   = 3'd0,
        ST_FOUND       = 3'd1,
        ST_END         = 3'd2,
        ST_NO_PRESENCE = 3'd3,
        ST_NO_RESPONSE = 3'd4,
        ST_CRC_FAIL    = 3'd5,
        ST_ZERO_FAMILY = 3'd6,
        ST_SETUP       = 3'd7
    } status_t;

    localparam logic [7:0] CRC_POLY           = 8'h8C;
    localparam logic [6:0] END_POSITION       = 7'd65;
    localparam logic [6:0] FAMILY_LIMIT       = 7'd9;
    localparam logic [6:0] TARGET_DISCREPANCY = 7'd64;
    localparam int         ID_BITS            = 64;

    typedef struct packed {
        logic [2:0] command;
        logic       presence;
        logic       id_bit;
        logic       complement_bit;
        logic       taken_direction;
        logic [7:0] target_family;
    } item_t;

    typedef struct packed {
        logic               request_direction;
        logic [2:0]         status;
        logic [ID_BITS-1:0] device_id;
    } result_t;

    typedef struct packed {
        logic [ID_BITS-1:0] rom_id;
        logic [6:0]         last_discrepancy;
        logic [3:0]         last_family_discrepancy;
        logic               last_device;
        logic [6:0]         bit_position;
        logic [6:0]         zero_taken_pos;
        logic [7:0]         running_crc;
        logic               search_active;
    } state_t;

    // Dallas CRC-8, reflected, one byte folded in
    function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // Direction to request for ID bit n (counting from 1)
    function automatic logic direction_for(input logic [6:0] n, input logic [6:0] ld,
                                           input logic [ID_BITS-1:0] rom);
        logic [5:0] idx;
        idx = n[5:0] - 6'd1;
        if (n < ld) begin
            return rom[idx];
        end
        return (n == ld);
    endfunction

endpackage

### hw/rtl/onewire_rom_search_engine.sv
// 1-Wire ROM search engine, one ID bit per transaction.
// Input channel (s_): each transaction carries a command in s_tuser (start first,
// start next, bit result, target family, skip family) and its operands in
// s_tdata (presence, id bit, complement bit, taken direction, target family).
// Result channel (m_): exactly one transaction per input transaction, carrying
// the status in m_tuser and the next request direction plus the 64-bit ROM ID
// in m_tdata.
// An accepted transaction lands in the input register; the search state and the
// result register update when it advances out of it, and the result then shows
// on m_tvalid.
// Throughput: one transaction per cycle unless the result stalls; the bit step
// and byte CRC fold are one combinational pass from the input register to the
// result register, and the search state feeds back to itself within that cycle.
// Reset (aresetn low, synchronous): both stages empty, ROM ID and counters zero,
// bit position one, no search open.
// Stall: when m_tready is low the result holds; one more transaction can wait in
// the input register, after which s_tready drops until the result is taken.
module onewire_rom_search_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] presence, [1] id_bit, [2] complement_bit, [3] taken_direction,
    // [11:4] target family, [15:12] zero
    input  logic [15:0] s_tdata,
    // [2:0] command
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] request_direction, [64:1] device_id, [71:65] zero
    output logic [71:0] m_tdata,
    // [2:0] status
    output logic [2:0]  m_tuser
);

    ors_pkg::item_t   in_reg;
    logic             in_vld_reg;
    ors_pkg::result_t out_reg;
    logic             out_vld_reg;
    ors_pkg::state_t  state_reg;
    ors_pkg::state_t  state_next;
    ors_pkg::result_t res_next;
    logic             advance;

    // Move the input stage forward whenever the result stage is free or drains
    assign advance  = !out_vld_reg || m_tready;
    assign s_tready = !in_vld_reg || advance;

    ors_step u_step (
        .item (in_reg),
        .cur  (state_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    // Input register: capture a transaction, hold it while the result stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_reg.command         <= s_tuser;
            in_reg.presence        <= s_tdata[0];
            in_reg.id_bit          <= s_tdata[1];
            in_reg.complement_bit  <= s_tdata[2];
            in_reg.taken_direction <= s_tdata[3];
            in_reg.target_family   <= s_tdata[11:4];
        end
    end

    // Search state and result register: update only when an item advances
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg                       <= 1'b0;
            state_reg.rom_id                  <= '0;
            state_reg.last_discrepancy        <= '0;
            state_reg.last_family_discrepancy <= '0;
            state_reg.last_device             <= 1'b0;
            state_reg.bit_position            <= 7'd1;
            state_reg.zero_taken_pos          <= '0;
            state_reg.running_crc             <= '0;
            state_reg.search_active           <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= in_vld_reg;
            if (in_vld_reg) begin
                state_reg <= state_next;
            end
        end
        if (advance && in_vld_reg) begin
            out_reg <= res_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'd0, out_reg.device_id, out_reg.request_direction};
    assign m_tuser  = out_reg.status;

endmodule

### hw/rtl/ors_step.sv
module ors_step (
    input  ors_pkg::item_t   item,
    input  ors_pkg::state_t  cur,
    output ors_pkg::state_t  nxt,
    output ors_pkg::result_t res
);

    logic [5:0] idx;
    logic [6:0] bp_inc;
    logic [2:0] status;
    logic       req;

    always_comb begin
        nxt    = cur;
        status = ors_pkg::ST_NO_RESPONSE;
        req    = 1'b0;
        idx    = cur.bit_position[5:0] - 6'd1;
        bp_inc = cur.bit_position + 7'd1;
        case (ors_pkg::command_t'(item.command))
            ors_pkg::CMD_START_FIRST, ors_pkg::CMD_START_NEXT: begin
                if (item.command == ors_pkg::CMD_START_FIRST) begin
                    nxt.last_discrepancy        = '0;
                    nxt.last_family_discrepancy = '0;
                    nxt.last_device             = 1'b0;
                end
                nxt.bit_position   = 7'd1;
                nxt.zero_taken_pos = '0;
                nxt.running_crc    = '0;
                nxt.search_active  = 1'b0;
                if (nxt.last_device) begin
                    nxt.last_discrepancy        = '0;
                    nxt.last_family_discrepancy = '0;
                    nxt.last_device             = 1'b0;
                    status                      = ors_pkg::ST_END;
                end else if (!item.presence) begin
                    nxt.last_discrepancy        = '0;
                    nxt.last_family_discrepancy = '0;
                    status                      = ors_pkg::ST_NO_PRESENCE;
                end else begin
                    nxt.search_active = 1'b1;
                    status            = ors_pkg::ST_SEARCHING;
                    req = ors_pkg::direction_for(7'd1, nxt.last_discrepancy, nxt.rom_id);
                end
            end
            ors_pkg::CMD_BIT_RESULT: begin
                if (cur.search_active) begin
                    if (item.id_bit && item.complement_bit) begin
                        // no device answered: close and forget the search path
                        nxt.search_active           = 1'b0;
                        nxt.last_discrepancy        = '0;
                        nxt.last_family_discrepancy = '0;
                        nxt.last_device             = 1'b0;
                        status                      = ors_pkg::ST_NO_RESPONSE;
                    end else begin
                        if (!item.id_bit && !item.complement_bit && !item.taken_direction) begin
                            nxt.zero_taken_pos = cur.bit_position;
                            if (cur.bit_position < ors_pkg::FAMILY_LIMIT) begin
                                nxt.last_family_discrepancy = cur.bit_position[3:0];
                            end
                        end
                        nxt.rom_id[idx] = item.taken_direction;
                        if (idx[2:0] == 3'd7) begin
                            nxt.running_crc = ors_pkg::crc_byte(cur.running_crc,
                                nxt.rom_id[{idx[5:3], 3'b000} +: 8]);
                        end
                        nxt.bit_position = bp_inc;
                        if (bp_inc >= ors_pkg::END_POSITION) begin
                            nxt.search_active = 1'b0;
                            if (nxt.running_crc != 8'd0) begin
                                nxt.last_discrepancy        = '0;
                                nxt.last_family_discrepancy = '0;
                                nxt.last_device             = 1'b0;
                                status                      = ors_pkg::ST_CRC_FAIL;
                            end else begin
                                nxt.last_discrepancy = nxt.zero_taken_pos;
                                if (nxt.zero_taken_pos == 7'd0) begin
                                    nxt.last_device = 1'b1;
                                end
                                if (nxt.rom_id[7:0] == 8'd0) begin
                                    nxt.last_discrepancy        = '0;
                                    nxt.last_family_discrepancy = '0;
                                    nxt.last_device             = 1'b0;
                                    status                      = ors_pkg::ST_ZERO_FAMILY;
                                end else begin
                                    status = ors_pkg::ST_FOUND;
                                end
                            end
                        end else begin
                            status = ors_pkg::ST_SEARCHING;
                            req = ors_pkg::direction_for(bp_inc, cur.last_discrepancy,
                                                         nxt.rom_id);
                        end
                    end
                end
            end
            ors_pkg::CMD_TARGET_FAM: begin
                nxt.rom_id                  = {{(ors_pkg::ID_BITS-8){1'b0}}, item.target_family};
                nxt.last_discrepancy        = ors_pkg::TARGET_DISCREPANCY;
                nxt.last_family_discrepancy = '0;
                nxt.last_device             = 1'b0;
                nxt.search_active           = 1'b0;
                status                      = ors_pkg::ST_SETUP;
            end
            ors_pkg::CMD_SKIP_FAM: begin
                nxt.last_discrepancy        = {3'b000, cur.last_family_discrepancy};
                nxt.last_family_discrepancy = '0;
                if (cur.last_family_discrepancy == 4'd0) begin
                    nxt.last_device = 1'b1;
                end
                nxt.search_active = 1'b0;
                status            = ors_pkg::ST_SETUP;
            end
            default: begin
            end
        endcase
        res.request_direction = req;
        res.status            = status;
        res.device_id         = nxt.rom_id;
    end

endmodule
